// ===== hdl/g2r_pkg.sv =====
// Package for the glob to regex translator: character codes, the command
// record passed from the front end to the emitter, and the tail table.
// No dependencies.
package g2r_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] C_CARET  = 8'h5E;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_QMARK  = 8'h3F;
    localparam logic [7:0] C_BAR    = 8'h7C;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;
    localparam logic [7:0] C_LBRACK = 8'h5B;
    localparam logic [7:0] C_RBRACK = 8'h5D;
    localparam logic [7:0] C_BANG   = 8'h21;
    localparam logic [7:0] C_NL     = 8'h0A;
    localparam logic [7:0] C_DOLLAR = 8'h24;

    // Number of bytes in the closing tail "(?!\n)$".
    localparam logic [2:0] C_TAIL_LEN = 3'd6;

    // One classified item: which bytes the emitter still has to produce.
    typedef struct packed {
        logic       caret;     // leading '^' of a new pattern
        logic       pre_en;    // a prefix byte comes before the body
        logic       pre_dot;   // prefix is '.', otherwise a backslash
        logic       body_en;   // the body byte is present
        logic [7:0] body_char;
        logic       tail;      // closing tail follows
    } t_cmd;

    // Tail byte selected by the number of tail bytes still to go.
    function automatic logic [7:0] tail_byte(input logic [2:0] remaining);
        logic [7:0] b;
        b = C_DOLLAR;
        unique case (remaining)
            3'd6:    b = C_LPAREN;
            3'd5:    b = C_QMARK;
            3'd4:    b = C_BANG;
            3'd3:    b = C_NL;
            3'd2:    b = C_RPAREN;
            default: b = C_DOLLAR;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/glob_to_regex_translator.sv =====
// Channel   | Direction | Handshake        | Payload
// glob in   | input     | i_push / o_full  | i_ch, i_end_of_pattern
// regex out | output    | o_empty / i_pop  | o_out_char, o_last
//
// Each accepted item yields zero to three regex bytes for a character and
// up to eight for the end item; the emitter produces one byte per cycle
// while the receiver takes them, which sets the sustained rate.
// The front end takes one item per cycle while the four-entry command queue
// has room. Results pass the queue, the emitter and the output register.
// Synchronous reset clears the pattern state, the queue and the output stage.
// Top level: front end, command queue and emitter. Depends on g2r_pkg and
// the g2r_front, g2r_fifo and g2r_back modules.
module glob_to_regex_translator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_ch,
    input  logic       i_end_of_pattern,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_char,
    output logic       o_last
);
    import g2r_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_push;
    logic queue_full;
    logic queue_empty;
    logic queue_pop;

    g2r_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .i_ch             (i_ch),
        .i_end_of_pattern (i_end_of_pattern),
        .i_full           (queue_full),
        .o_cmd_push       (front_push),
        .o_cmd            (front_cmd)
    );

    g2r_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_cmd   (queue_cmd),
        .o_empty (queue_empty)
    );

    g2r_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_empty (queue_empty),
        .o_cmd_pop   (queue_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

    assign o_full = queue_full;

endmodule

// ===== hdl/g2r_front.sv =====
// Front end of the translator: takes glob bytes, keeps the pattern state
// and turns each byte into a command record for the emitter.
// Depends on g2r_pkg.
module g2r_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [7:0]     i_ch,
    input  logic           i_end_of_pattern,
    input  logic           i_full,
    output logic           o_cmd_push,
    output g2r_pkg::t_cmd  o_cmd
);
    import g2r_pkg::*;

    logic r_pending;
    logic r_started;
    logic n_pending;
    logic n_started;
    logic emit;
    logic accept;
    t_cmd cmd;

    assign accept = i_push && !i_full;

    always_comb begin
        cmd           = '0;
        cmd.caret     = !r_started;
        cmd.body_char = i_ch;
        emit          = 1'b1;
        n_pending     = 1'b0;
        n_started     = 1'b1;
        if (i_end_of_pattern) begin
            cmd.pre_en = r_pending;
            cmd.tail   = 1'b1;
            n_started  = 1'b0;
        end else begin
            unique case (i_ch) inside
                C_BSLASH: begin
                    if (r_pending) begin
                        cmd.pre_en  = 1'b1;
                        cmd.body_en = 1'b1;
                    end else begin
                        n_pending = 1'b1;
                        // Nothing to send unless this opens a pattern.
                        emit      = !r_started;
                    end
                end
                C_STAR: begin
                    cmd.pre_en  = 1'b1;
                    cmd.pre_dot = !r_pending;
                    cmd.body_en = 1'b1;
                end
                C_QMARK: begin
                    cmd.pre_en  = r_pending;
                    cmd.body_en = 1'b1;
                    if (!r_pending) begin
                        cmd.body_char = C_DOT;
                    end
                end
                C_DOT, C_BAR, C_PLUS, C_LPAREN, C_RPAREN, C_LBRACE, C_RBRACE: begin
                    cmd.pre_en  = 1'b1;
                    cmd.body_en = 1'b1;
                end
                C_LBRACK, C_RBRACK: begin
                    cmd.pre_en  = r_pending;
                    cmd.body_en = 1'b1;
                end
                default: begin
                    cmd.body_en = 1'b1;
                end
            endcase
        end
    end

    assign o_cmd      = cmd;
    assign o_cmd_push = accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_started <= 1'b0;
        end else if (accept) begin
            r_pending <= n_pending;
            r_started <= n_started;
        end
    end

endmodule

// ===== hdl/g2r_fifo.sv =====
// Short command queue between the front end and the emitter.
// Depends on g2r_pkg.
module g2r_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  g2r_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output g2r_pkg::t_cmd  o_cmd,
    output logic           o_empty
);
    import g2r_pkg::*;

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/g2r_back.sv =====
// Emitter of the translator: works through one command record at a time,
// producing one regex byte per cycle unless the output register is stalled.
// Depends on g2r_pkg.
module g2r_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  g2r_pkg::t_cmd  i_cmd,
    input  logic           i_cmd_empty,
    output logic           o_cmd_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_out_char,
    output logic           o_last
);
    import g2r_pkg::*;

    logic       r_caret;
    logic       r_pre;
    logic       r_pre_dot;
    logic       r_body;
    logic [7:0] r_body_char;
    logic [2:0] r_tail_cnt;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;

    logic       n_caret;
    logic       n_pre;
    logic       n_body;
    logic [2:0] n_tail_cnt;
    logic [7:0] emit_char;
    logic       emit_last;
    logic       active;
    logic       advance;
    logic       rest_empty;
    logic       load;

    assign active  = r_caret || r_pre || r_body || (r_tail_cnt != '0);
    assign advance = !r_out_valid || i_pop;

    // Pick the first outstanding byte and work out what is left after it.
    always_comb begin
        n_caret    = r_caret;
        n_pre      = r_pre;
        n_body     = r_body;
        n_tail_cnt = r_tail_cnt;
        emit_char  = tail_byte(r_tail_cnt);
        emit_last  = 1'b0;
        if (r_caret) begin
            emit_char = C_CARET;
            n_caret   = 1'b0;
        end else if (r_pre) begin
            emit_char = r_pre_dot ? C_DOT : C_BSLASH;
            n_pre     = 1'b0;
        end else if (r_body) begin
            emit_char = r_body_char;
            n_body    = 1'b0;
        end else if (r_tail_cnt != '0) begin
            emit_last  = (r_tail_cnt == 3'd1);
            n_tail_cnt = r_tail_cnt - 1'b1;
        end
    end

    assign rest_empty = !(n_caret || n_pre || n_body || (n_tail_cnt != '0));
    assign load       = (!active || (advance && rest_empty)) && !i_cmd_empty;
    assign o_cmd_pop  = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caret     <= 1'b0;
            r_pre       <= 1'b0;
            r_body      <= 1'b0;
            r_tail_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_caret     <= i_cmd.caret;
                r_pre       <= i_cmd.pre_en;
                r_pre_dot   <= i_cmd.pre_dot;
                r_body      <= i_cmd.body_en;
                r_body_char <= i_cmd.body_char;
                r_tail_cnt  <= i_cmd.tail ? C_TAIL_LEN : 3'd0;
            end else if (advance && active) begin
                r_caret    <= n_caret;
                r_pre      <= n_pre;
                r_body     <= n_body;
                r_tail_cnt <= n_tail_cnt;
            end
            if (advance) begin
                r_out_valid <= active;
                r_out_char  <= emit_char;
                r_out_last  <= emit_last;
            end
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_char = r_out_char;
    assign o_last     = r_out_last;

endmodule

// ===== hdl/g2r_checker.sv =====
// Port-level checks for the glob to regex translator, bound to its top level.
// Depends on g2r_pkg.
module g2r_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_empty,
    input logic       i_pop,
    input logic [7:0] o_out_char,
    input logic       o_last
);
    import g2r_pkg::*;

    // Set once the final byte of a pattern has been transferred out, so the
    // next result must open a new pattern.
    logic r_after_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_last <= 1'b1;
        end else if (i_pop && !o_empty) begin
            r_after_last <= o_last;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("output not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_out_char) && $stable(o_last)))
        else $error("waiting result changed before transfer");

    a_last_dollar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_last) |-> (o_out_char == C_DOLLAR))
        else $error("last flag on a byte other than the closing anchor");

    a_open_caret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && r_after_last) |-> (o_out_char == C_CARET && !o_last))
        else $error("pattern does not open with the start anchor");

endmodule

bind glob_to_regex_translator g2r_checker u_g2r_checker (.*);

// ===== test/tb.sv =====
// Self-checking testbench for glob_to_regex_translator: glob bytes are
// pushed in and every regex byte that comes out is checked against a
// predictor of the translation. Depends on g2r_pkg and the translator RTL.
module tb;
    import g2r_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LONG_HOLD      = 60;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_regex_byte;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_push;
    logic       o_full;
    logic [7:0] i_ch;
    logic       i_end_of_pattern;
    logic       o_empty;
    logic       i_pop;
    logic [7:0] o_out_char;
    logic       o_last;

    glob_to_regex_translator i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_ch             (i_ch),
        .i_end_of_pattern (i_end_of_pattern),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_out_char       (o_out_char),
        .o_last           (o_last)
    );

    t_regex_byte expected_regex[$];
    logic        bs_held;
    logic        pat_open;
    int          errors = 0;
    int          items_sent;
    int          quiet_cycles = 0;
    int          hold_req;
    bit          idle_on;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic void expect_byte(input logic [7:0] ch, input logic last);
        t_regex_byte b;
        b.ch   = ch;
        b.last = last;
        expected_regex.push_back(b);
    endfunction

    // Works out the regex bytes that one glob item gives and updates the
    // pattern state in the same way as the block.
    function automatic void translate_glob(input logic [7:0] ch, input logic eop);
        if (!pat_open) begin
            expect_byte(C_CARET, 1'b0);
            pat_open = 1'b1;
        end
        if (eop) begin
            if (bs_held)
                expect_byte(C_BSLASH, 1'b0);
            expect_byte(C_LPAREN, 1'b0);
            expect_byte(C_QMARK, 1'b0);
            expect_byte(C_BANG, 1'b0);
            expect_byte(C_NL, 1'b0);
            expect_byte(C_RPAREN, 1'b0);
            expect_byte(C_DOLLAR, 1'b1);
            bs_held  = 1'b0;
            pat_open = 1'b0;
        end else if (ch == C_BSLASH) begin
            if (bs_held) begin
                expect_byte(C_BSLASH, 1'b0);
                expect_byte(C_BSLASH, 1'b0);
            end
            bs_held = !bs_held;
        end else begin
            if (ch == C_STAR) begin
                expect_byte(bs_held ? C_BSLASH : C_DOT, 1'b0);
                expect_byte(C_STAR, 1'b0);
            end else if (ch == C_QMARK) begin
                if (bs_held) begin
                    expect_byte(C_BSLASH, 1'b0);
                    expect_byte(C_QMARK, 1'b0);
                end else begin
                    expect_byte(C_DOT, 1'b0);
                end
            end else if (ch inside {C_DOT, C_BAR, C_PLUS, C_LPAREN, C_RPAREN,
                                    C_LBRACE, C_RBRACE}) begin
                expect_byte(C_BSLASH, 1'b0);
                expect_byte(ch, 1'b0);
            end else if (ch == C_LBRACK || ch == C_RBRACK) begin
                if (bs_held)
                    expect_byte(C_BSLASH, 1'b0);
                expect_byte(ch, 1'b0);
            end else begin
                // An ordinary byte simply drops a held backslash.
                expect_byte(ch, 1'b0);
            end
            bs_held = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch: %s got %02h expected %02h", what, got, want);
        errors++;
    endtask

    // Offers one item and returns once its transfer has taken place; push is
    // left high so that a following item can go straight out.
    task automatic send_glob(input logic [7:0] ch, input logic eop);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap    = $urandom_range(1, 4);
            i_push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_ch             = ch;
        i_end_of_pattern = eop;
        i_push           = 1'b1;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        translate_glob(ch, eop);
        items_sent++;
    endtask

    function automatic logic [7:0] pick_glob_char();
        logic [7:0] specials[7];
        int         r;
        specials = '{C_DOT, C_BAR, C_PLUS, C_LPAREN, C_RPAREN, C_LBRACE, C_RBRACE};
        r = $urandom_range(0, 9);
        case (r)
            0, 1:    return C_BSLASH;
            2:       return C_STAR;
            3:       return C_QMARK;
            4:       return specials[$urandom_range(0, 6)];
            5:       return ($urandom_range(0, 1) != 0) ? C_LBRACK : C_RBRACK;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pattern(input int len);
        for (int k = 0; k < len; k++)
            send_glob(pick_glob_char(), 1'b0);
        send_glob(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_empty_pattern();
        send_glob(8'h00, 1'b1);
    endtask

    task automatic test_special_chars();
        send_glob(8'h00, 1'b0);
        send_glob(C_STAR, 1'b0);
        send_glob(C_QMARK, 1'b0);
        send_glob(C_DOT, 1'b0);
        send_glob(C_BAR, 1'b0);
        send_glob(C_PLUS, 1'b0);
        send_glob(C_LPAREN, 1'b0);
        send_glob(C_RPAREN, 1'b0);
        send_glob(C_LBRACE, 1'b0);
        send_glob(C_RBRACE, 1'b0);
        send_glob(C_LBRACK, 1'b0);
        send_glob(C_RBRACK, 1'b0);
        send_glob(8'hFF, 1'b1);
    endtask

    task automatic test_backslash_hold();
        logic [7:0] follow[5];
        follow = '{C_BSLASH, C_STAR, C_QMARK, C_RBRACK, 8'hFF};
        foreach (follow[k]) begin
            send_glob(C_BSLASH, 1'b0);
            send_glob(follow[k], 1'b0);
        end
        // A backslash still held at the end is flushed before the tail.
        send_glob(C_BSLASH, 1'b0);
        send_glob(8'h00, 1'b1);
    endtask

    task automatic test_back_pressure();
        hold_req = LONG_HOLD;
        for (int k = 0; k < 24; k++)
            send_glob(pick_glob_char(), 1'b0);
        send_glob(8'h00, 1'b1);
    endtask

    task automatic test_random_patterns();
        while (items_sent < 320)
            send_pattern($urandom_range(0, 10));
    endtask

    task automatic test_random_noise();
        for (int k = 0; k < 50; k++)
            send_glob(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        while (items_sent < 420)
            send_pattern($urandom_range(0, 8));
    endtask

    // Receiver: random stalls, plus one long hold counted here when asked.
    initial begin
        int stall;
        stall = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                stall    = hold_req;
                hold_req = 0;
            end else if (stall == 0 && idle_on && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 4);
            end
            if (stall > 0) begin
                i_pop = 1'b0;
                stall--;
            end else begin
                i_pop = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_regex_byte want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_regex.size() == 0) begin
                report_mismatch("unexpected byte", o_out_char, 8'h00);
            end else begin
                want = expected_regex.pop_front();
                if (o_out_char !== want.ch)
                    report_mismatch("out_char", o_out_char, want.ch);
                if (o_last !== want.last)
                    report_mismatch("last", {7'd0, o_last}, {7'd0, want.last});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_push           = 1'b0;
        i_pop            = 1'b0;
        i_ch             = 8'h00;
        i_end_of_pattern = 1'b0;
        bs_held          = 1'b0;
        pat_open         = 1'b0;
        items_sent       = 0;
        hold_req         = 0;
        idle_on          = 1'b1;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_pattern();
        test_special_chars();
        test_backslash_hold();
        test_back_pressure();
        test_random_patterns();
        test_random_noise();
        test_steady_stream();

        @(negedge i_clk);
        i_push = 1'b0;
        while (expected_regex.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/g2r_pkg.sv
hdl/g2r_front.sv
hdl/g2r_fifo.sv
hdl/g2r_back.sv
hdl/glob_to_regex_translator.sv
hdl/g2r_checker.sv
test/tb.sv
